// ===== rtl/core/fasta_record_field_splitter_assert.svh =====
// ----------------------------------------------------------------------------
// FASTA record field splitter assertion macros
// Shared concurrent assertion forms for the splitter RTL.
// ----------------------------------------------------------------------------
`ifndef FASTA_RECORD_FIELD_SPLITTER_ASSERT_SVH
`define FASTA_RECORD_FIELD_SPLITTER_ASSERT_SVH

// cons must hold in the same cycle as ante
`define FRFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define FRFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/frfs_pkg.sv =====
// ----------------------------------------------------------------------------
// FASTA record field splitter package
// Result item, request bundle and queue status types plus character codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frfs_pkg;

	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [1:0] KIND_ID  = 2'd0;
	localparam logic [1:0] KIND_COM = 2'd1;
	localparam logic [1:0] KIND_SEQ = 2'd2;

	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       valid;
		logic       fend;
		logic       rend;
		logic       ferr;
	} result_t;

	typedef struct packed {
		logic [1:0]                count;
		result_t [MAX_RES-1:0]     res;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/frfs_front.sv =====
// ----------------------------------------------------------------------------
// FASTA record field splitter front end
// Parses one input byte per cycle while the queue is not full and pushes its result bundle, if any, to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frfs_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [7:0] in_byte
	input  wire logic              s_tlast,   // end_of_file
	input  wire frfs_pkg::q_stat_t q_stat,
	output logic                   push,
	output frfs_pkg::bundle_t      push_data
);
	import frfs_pkg::*;

	typedef enum logic [2:0] {
		ST_START   = 3'd0,
		ST_ID      = 3'd1,
		ST_SKIPSP  = 3'd2,
		ST_COMMENT = 3'd3,
		ST_SEQ     = 3'd4,
		ST_ERROR   = 3'd5
	} st_t;

	st_t                   st_q, st_mid, st_d;
	logic                  drop_q, drop_d;
	logic                  ls_q, ls_d;
	logic [1:0]            n;
	result_t [MAX_RES-1:0] res_v;
	logic                  eol;
	logic                  accept;

	function automatic result_t mk(input logic [1:0] kind, input logic [7:0] data,
		input logic valid, input logic fend, input logic rend, input logic ferr);
		result_t r;
		r.kind  = kind;
		r.data  = valid ? data : 8'h00;
		r.valid = valid;
		r.fend  = fend;
		r.rend  = rend;
		r.ferr  = ferr;
		return r;
	endfunction

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign eol      = (s_tdata == CH_LF) || (s_tdata == CH_CR);

	always_comb begin
		res_v  = '0;
		n      = 2'd0;
		st_mid = st_q;
		drop_d = drop_q;
		ls_d   = ls_q;
		case (st_q)
			ST_START: begin
				if (s_tdata == CH_GT) begin
					st_mid = ST_ID;
				end else begin
					res_v[n] = mk(KIND_ID, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
					n        = n + 2'd1;
					st_mid   = ST_ERROR;
				end
			end
			ST_ID: begin
				if ((s_tdata == CH_SP) || (s_tdata == CH_TAB)) begin
					res_v[n] = mk(KIND_ID, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
					n        = n + 2'd1;
					st_mid   = ST_SKIPSP;
				end else if (eol) begin
					res_v[n] = mk(KIND_ID, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
					n        = n + 2'd1;
					st_mid   = ST_SEQ;
					ls_d     = 1'b1;
					drop_d   = (s_tdata == CH_CR);
				end else begin
					res_v[n] = mk(KIND_ID, s_tdata, 1'b1, 1'b0, 1'b0, 1'b0);
					n        = n + 2'd1;
				end
			end
			ST_SKIPSP: begin
				if (s_tdata == CH_SP) begin
					st_mid = ST_SKIPSP;
				end else if (eol) begin
					res_v[n] = mk(KIND_COM, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
					n        = n + 2'd1;
					st_mid   = ST_SEQ;
					ls_d     = 1'b1;
					drop_d   = (s_tdata == CH_CR);
				end else begin
					res_v[n] = mk(KIND_COM, s_tdata, 1'b1, 1'b0, 1'b0, 1'b0);
					n        = n + 2'd1;
					st_mid   = ST_COMMENT;
				end
			end
			ST_COMMENT: begin
				if (eol) begin
					res_v[n] = mk(KIND_COM, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
					n        = n + 2'd1;
					st_mid   = ST_SEQ;
					ls_d     = 1'b1;
					drop_d   = (s_tdata == CH_CR);
				end else begin
					res_v[n] = mk(KIND_COM, s_tdata, 1'b1, 1'b0, 1'b0, 1'b0);
					n        = n + 2'd1;
				end
			end
			ST_SEQ: begin
				if (drop_q && (s_tdata == CH_LF)) begin
					drop_d = 1'b0;
				end else if (eol) begin
					ls_d   = 1'b1;
					drop_d = (s_tdata == CH_CR);
				end else if ((s_tdata == CH_GT) && ls_q) begin
					res_v[n] = mk(KIND_SEQ, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
					n        = n + 2'd1;
					st_mid   = ST_ID;
					ls_d     = 1'b0;
					drop_d   = 1'b0;
				end else begin
					res_v[n] = mk(KIND_SEQ, s_tdata, 1'b1, 1'b0, 1'b0, 1'b0);
					n        = n + 2'd1;
					ls_d     = 1'b0;
					drop_d   = 1'b0;
				end
			end
			default: begin
				st_mid = st_q;
			end
		endcase

		st_d = st_mid;
		if (s_tlast) begin
			case (st_mid)
				ST_ID: begin
					res_v[n] = mk(KIND_ID, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
					n        = n + 2'd1;
					res_v[n] = mk(KIND_SEQ, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
					n        = n + 2'd1;
				end
				ST_SKIPSP, ST_COMMENT: begin
					res_v[n] = mk(KIND_COM, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
					n        = n + 2'd1;
					res_v[n] = mk(KIND_SEQ, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
					n        = n + 2'd1;
				end
				ST_SEQ: begin
					res_v[n] = mk(KIND_SEQ, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
					n        = n + 2'd1;
				end
				default: begin
					n = n;
				end
			endcase
			st_d   = ST_START;
			drop_d = 1'b0;
			ls_d   = 1'b0;
		end
	end

	assign push            = accept && (n != 2'd0);
	assign push_data.count = n;
	assign push_data.res   = res_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_START;
			drop_q <= 1'b0;
			ls_q   <= 1'b0;
		end else if (accept) begin
			st_q   <= st_d;
			drop_q <= drop_d;
			ls_q   <= ls_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/frfs_queue.sv =====
// ----------------------------------------------------------------------------
// FASTA record field splitter request queue
// Short register queue of result bundles between front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fasta_record_field_splitter_assert.svh"

module frfs_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire frfs_pkg::bundle_t push_data,
	input  wire logic              pop,
	output frfs_pkg::bundle_t      head,
	output frfs_pkg::q_stat_t      q_stat
);
	import frfs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	bundle_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == FULL_CNT);
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`FRFS_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !q_stat.full, "push into full queue")
	`FRFS_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !q_stat.empty, "pop from empty queue")
	`FRFS_ASSERT_IMP(a_push_nonempty, clk, arst_n, push, push_data.count != 2'd0, "empty bundle pushed")

endmodule

`default_nettype wire

// ===== rtl/core/frfs_back.sv =====
// ----------------------------------------------------------------------------
// FASTA record field splitter back end
// Sends the results of the head bundle one per cycle, while m_tready is high, on the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fasta_record_field_splitter_assert.svh"

module frfs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire frfs_pkg::bundle_t head,
	input  wire frfs_pkg::q_stat_t q_stat,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,   // [7:0] out_byte
	output logic [5:0]             m_tuser,   // [1:0] field_kind, [2] byte_valid,
	                                          // [3] field_end, [4] record_end,
	                                          // [5] format_error
	output logic                   m_tlast    // run_last
);
	import frfs_pkg::*;

	logic [1:0] idx_q;
	result_t    cur;
	logic       last;

	assign cur      = head.res[idx_q];
	assign last     = (idx_q == (head.count - 2'd1));
	assign m_tvalid = !q_stat.empty;
	assign m_tdata  = cur.data;
	assign m_tuser  = {cur.ferr, cur.rend, cur.fend, cur.valid, cur.kind};
	assign m_tlast  = last;
	assign pop      = m_tvalid && m_tready && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	`FRFS_ASSERT_IMP(a_idx_in_bundle, clk, arst_n, m_tvalid, idx_q < head.count, "index past bundle")
	`FRFS_ASSERT_IMP(a_err_is_last, clk, arst_n, m_tvalid && cur.ferr, last, "error not last result")
	`FRFS_ASSERT_NEXT(a_hold_idx, clk, arst_n, m_tvalid && !m_tready, $stable(idx_q), "index moved in stall")

endmodule

`default_nettype wire

// ===== rtl/core/fasta_record_field_splitter.sv =====
// ----------------------------------------------------------------------------
// FASTA record field splitter
// Splits a FASTA byte stream into tagged id, comment and sequence field items.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the queue has room. Each byte gives
// zero to three results; any results are packed by the parser into one queue
// entry. The output side sends one result per cycle while m_tready is high, so
// a byte's results go out one after another (three at most, when end of file
// closes open fields). The results of a byte are registered in the queue before
// they appear on the output. A queue of QUEUE_DEPTH entries lets the two sides
// stall independently; input stops only when it is full.
`timescale 1ns / 1ps
`default_nettype none

module fasta_record_field_splitter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // end_of_file
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic [5:0]      m_tuser,   // [1:0] field_kind, [2] byte_valid,
	                                   // [3] field_end, [4] record_end, [5] format_error
	output logic            m_tlast    // run_last
);
	import frfs_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	bundle_t push_data;
	bundle_t head;

	frfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	frfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	frfs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
